// ===== hw/rtl/chm_pkg.sv =====
package chm_pkg;

    localparam int MAX_BUCKETS  = 64;
    localparam int POOL_ENTRIES = 256;
    localparam int BKT_W        = $clog2(MAX_BUCKETS);
    localparam int SLOT_W       = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = SLOT_W + 1;
    localparam int DATA_W       = 32;
    localparam int CFG_W        = 7;
    localparam int CNT_W        = 9;
    localparam int DIV_STEPS    = 32;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [LINK_W-1:0] NULL_LINK    = LINK_W'(POOL_ENTRIES);
    localparam logic [LINK_W-1:0] POOL_FULL_TOP = LINK_W'(POOL_ENTRIES);
    localparam logic [CFG_W-1:0]  CFG_RESET    = CFG_W'(64);
    localparam logic [CFG_W-1:0]  CFG_MAX      = CFG_W'(MAX_BUCKETS);
    localparam logic [DATA_W-1:0] INT_MAX      = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        REQ_GET = 2'd0,
        REQ_PUT = 2'd1,
        REQ_DEL = 2'd2,
        REQ_RSV = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_HEAD,
        S_HEAD_WT,
        S_CHK,
        S_ENT_WT,
        S_ACT,
        S_LINK,
        S_RESP
    } t_state;

endpackage

// ===== hw/rtl/chm_req_if.sv =====
interface chm_req_if;
    import chm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] req_key;
    logic signed [DATA_W-1:0] req_value;
    modport source (output valid, output req_type, output req_key, output req_value,
                    input ready);
    modport sink (input valid, input req_type, input req_key, input req_value,
                  output ready);
endinterface

// ===== hw/rtl/chm_rsp_if.sv =====
interface chm_rsp_if;
    import chm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] result_value;
    logic [CNT_W-1:0]         entry_count;
    logic [DATA_W-1:0]        op_count;
    modport source (output valid, output status, output result_value,
                    output entry_count, output op_count, input ready);
    modport sink (input valid, input status, input result_value,
                  input entry_count, input op_count, output ready);
endinterface

// ===== hw/rtl/chm_cfg_if.sv =====
interface chm_cfg_if;
    import chm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] bucket_count;
    modport source (output valid, output bucket_count, input ready);
    modport sink (input valid, input bucket_count, output ready);
endinterface

// ===== hw/rtl/chm_ram.sv =====
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/chm_mod.sv =====
module chm_mod
    import chm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_key,
    input  logic [CFG_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [BKT_W-1:0]  o_bucket
);
    logic                 r_busy, n_busy;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0]    r_key, n_key;
    logic [CFG_W-1:0]     r_rem, n_rem;
    logic [CFG_W-1:0]     trial;

    always_comb begin
        trial  = {r_rem[BKT_W-1:0], r_key[DATA_W-1]};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_key  = r_key;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_STEPS);
            n_key  = i_key;
            n_rem  = '0;
        end else if (r_busy) begin
            n_key = {r_key[DATA_W-2:0], 1'b0};
            n_rem = (trial >= i_divisor) ? trial - i_divisor : trial;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_key <= n_key;
        r_rem <= n_rem;
    end

    assign o_busy   = r_busy;
    assign o_bucket = r_rem[BKT_W-1:0];
endmodule

// ===== hw/rtl/chained_hash_map_engine_core.sv =====
// Channel  Dir  Word                                              Taken when
// i_req    in   req_type, req_key, req_value                      valid && ready
// o_rsp    out  status, result_value, entry_count, op_count       valid && ready
// i_cfg    in   bucket_count                                      valid (ready high)
//
// A request holds the block through the divide, the head read, a check of each chain
// entry walked, the action, a link step for a put of a new key, and the response.
// The bucket remainder is found by a restoring divider, one key bit per cycle.
// Each chain step is one registered read of the entry memories.
// Reset empties every chain at once through valid bits on the bucket heads.
// A waiting response holds off the next request.
module chained_hash_map_engine_core
    import chm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    chm_req_if.sink   i_req,
    chm_rsp_if.source o_rsp,
    chm_cfg_if.sink   i_cfg
);
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_bcnt;
    logic [1:0]          r_type;
    logic [DATA_W-1:0]   r_key, r_val;
    logic [LINK_W-1:0]   r_cur, n_cur, r_prev, n_prev, r_next, n_next;
    logic [CNT_W-1:0]    r_steps, n_steps;
    logic                r_found, n_found;
    logic [DATA_W-1:0]   r_old, n_old;
    logic [SLOT_W-1:0]   r_new, n_new;
    logic [LINK_W-1:0]   r_top, n_top, r_low, n_low;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [DATA_W-1:0]   r_ops, n_ops;
    logic [1:0]          r_status, n_status;
    logic [DATA_W-1:0]   r_result, n_result;
    logic [MAX_BUCKETS-1:0] r_head_vld;

    logic [CFG_W-1:0]    divisor;
    logic                div_busy;
    logic [BKT_W-1:0]    bucket;
    logic                accept;

    logic                head_we;
    logic [LINK_W-1:0]   head_wdata, head_rdata;
    logic                ent_we, link_we, val_we, free_we;
    logic [SLOT_W-1:0]   ent_waddr, link_waddr, val_waddr, free_waddr;
    logic [LINK_W-1:0]   link_wdata, link_rdata;
    logic [DATA_W-1:0]   val_wdata, val_rdata, key_rdata;
    logic [SLOT_W-1:0]   free_wdata, free_rdata, free_slot;
    logic [LINK_W-1:0]   top_m1;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_bcnt == '0) begin
            divisor = CFG_W'(1);
        end else if (r_bcnt > CFG_MAX) begin
            divisor = CFG_MAX;
        end else begin
            divisor = r_bcnt;
        end
    end

    chm_mod u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_key     (i_req.req_key),
        .i_divisor (divisor),
        .o_busy    (div_busy),
        .o_bucket  (bucket)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_heads (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(bucket), .i_wdata(head_wdata),
        .i_raddr(bucket), .o_rdata(head_rdata)
    );

    chm_ram #(.WIDTH(DATA_W), .DEPTH(POOL_ENTRIES)) u_keys (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(r_key),
        .i_raddr(r_cur[SLOT_W-1:0]), .o_rdata(key_rdata)
    );

    chm_ram #(.WIDTH(DATA_W), .DEPTH(POOL_ENTRIES)) u_vals (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(val_wdata),
        .i_raddr(r_cur[SLOT_W-1:0]), .o_rdata(val_rdata)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_links (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(r_cur[SLOT_W-1:0]), .o_rdata(link_rdata)
    );

    chm_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_ENTRIES)) u_free (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(free_waddr), .i_wdata(free_wdata),
        .i_raddr(top_m1[SLOT_W-1:0]), .o_rdata(free_rdata)
    );

    assign top_m1    = r_top - 1'b1;
    assign free_slot = (top_m1 < r_low) ? top_m1[SLOT_W-1:0] : free_rdata;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (accept) n_state = S_DIV;
            S_DIV:     if (!div_busy) n_state = S_HEAD;
            S_HEAD:    n_state = S_HEAD_WT;
            S_HEAD_WT: n_state = S_CHK;
            S_CHK: begin
                if (r_cur[SLOT_W] || r_steps == CNT_W'(POOL_ENTRIES)) begin
                    n_state = S_ACT;
                end else begin
                    n_state = S_ENT_WT;
                end
            end
            S_ENT_WT:  n_state = (key_rdata == r_key) ? S_ACT : S_CHK;
            S_ACT: begin
                if (r_type == REQ_PUT && !r_found && r_top != '0) begin
                    n_state = S_LINK;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_LINK:    n_state = S_RESP;
            S_RESP:    if (o_rsp.ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_next     = r_next;
        n_steps    = r_steps;
        n_found    = r_found;
        n_old      = r_old;
        n_new      = r_new;
        n_top      = r_top;
        n_low      = r_low;
        n_count    = r_count;
        n_ops      = r_ops;
        n_status   = r_status;
        n_result   = r_result;
        head_we    = 1'b0;
        head_wdata = r_next;
        ent_we     = 1'b0;
        ent_waddr  = free_slot;
        val_we     = 1'b0;
        val_waddr  = r_cur[SLOT_W-1:0];
        val_wdata  = r_val;
        link_we    = 1'b0;
        link_waddr = r_prev[SLOT_W-1:0];
        link_wdata = r_next;
        free_we    = 1'b0;
        free_waddr = r_top[SLOT_W-1:0];
        free_wdata = r_cur[SLOT_W-1:0];
        unique case (r_state)
            S_HEAD_WT: begin
                n_cur   = r_head_vld[bucket] ? head_rdata : NULL_LINK;
                n_prev  = NULL_LINK;
                n_steps = '0;
                n_found = 1'b0;
            end
            S_ENT_WT: begin
                if (key_rdata == r_key) begin
                    n_found = 1'b1;
                    n_old   = val_rdata;
                    n_next  = link_rdata;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = link_rdata;
                    n_steps = r_steps + 1'b1;
                end
            end
            S_ACT: begin
                n_status = r_found ? ST_FOUND : ST_ABSENT;
                n_result = r_found ? r_old : INT_MAX;
                case (r_type)
                    REQ_PUT: begin
                        if (r_found) begin
                            val_we = 1'b1;
                            n_ops  = r_ops + 1'b1;
                        end else if (r_top == '0) begin
                            n_status = ST_FULL;
                        end else begin
                            ent_we     = 1'b1;
                            val_we     = 1'b1;
                            val_waddr  = free_slot;
                            link_we    = 1'b1;
                            link_waddr = free_slot;
                            link_wdata = NULL_LINK;
                            n_new      = free_slot;
                            n_top      = top_m1;
                            if (top_m1 < r_low) begin
                                n_low = top_m1;
                            end
                            n_count = r_count + 1'b1;
                            n_ops   = r_ops + 1'b1;
                        end
                    end
                    REQ_DEL: begin
                        if (r_found) begin
                            if (r_prev[SLOT_W]) begin
                                head_we = 1'b1;
                            end else begin
                                link_we = 1'b1;
                            end
                            if (r_top < POOL_FULL_TOP) begin
                                free_we = 1'b1;
                                n_top   = r_top + 1'b1;
                            end
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        n_ops = r_ops + 1'b1;
                    end
                    default: begin
                        n_ops = r_ops + 1'b1;
                    end
                endcase
            end
            S_LINK: begin
                head_wdata = {1'b0, r_new};
                link_wdata = {1'b0, r_new};
                if (r_prev[SLOT_W]) begin
                    head_we = 1'b1;
                end else begin
                    link_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bcnt     <= CFG_RESET;
            r_top      <= POOL_FULL_TOP;
            r_low      <= POOL_FULL_TOP;
            r_count    <= '0;
            r_ops      <= '0;
            r_head_vld <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_bcnt <= i_cfg.bucket_count;
            end
            r_top   <= n_top;
            r_low   <= n_low;
            r_count <= n_count;
            r_ops   <= n_ops;
            if (head_we) begin
                r_head_vld[bucket] <= 1'b1;
            end
        end
        if (accept) begin
            r_type <= i_req.req_type;
            r_key  <= i_req.req_key;
            r_val  <= i_req.req_value;
        end
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_next   <= n_next;
        r_steps  <= n_steps;
        r_found  <= n_found;
        r_old    <= n_old;
        r_new    <= n_new;
        r_status <= n_status;
        r_result <= n_result;
    end

    assign o_rsp.valid        = (r_state == S_RESP);
    assign o_rsp.status       = r_status;
    assign o_rsp.result_value = r_result;
    assign o_rsp.entry_count  = r_count;
    assign o_rsp.op_count     = r_ops;
endmodule
